// ----- rtl/core/airx_pkg.sv -----
package airx_pkg;

  // Request codes carried in req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_FINAL = 2'd2,
    REQ_QUERY = 2'd3
  } req_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] base_address;
    logic [63:0] range_size;
  } in_word_t;

  typedef struct packed {
    logic       answer;
    logic [6:0] entries_held;
  } out_word_t;

  // What every cell of the row does this cycle.
  typedef enum logic [2:0] {
    C_HOLD  = 3'd0,
    C_LOAD  = 3'd1,
    C_WRITE = 3'd2,
    C_SHIFT = 3'd3,
    C_SORT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_ctl_t;

  // What the unit at the head of the row does this cycle.
  typedef enum logic [1:0] {
    H_IDLE  = 2'd0,
    H_MERGE = 2'd1,
    H_SCAN  = 2'd2
  } head_mode_t;

  typedef struct packed {
    head_mode_t mode;
    logic       clr;
  } head_ctl_t;

endpackage

// ----- rtl/core/airx_cell.sv -----
module airx_cell #(
  parameter int AW    = 64,
  parameter int CW    = 7,
  parameter int IDX   = 0,
  parameter int NCELL = 65
) (
  input  logic                clk,
  input  airx_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]       sel,
  input  logic [AW-1:0]       wr_start,
  input  logic [AW-1:0]       wr_stop,
  input  logic                dn_live,
  input  logic [AW-1:0]       dn_start,
  input  logic [AW-1:0]       dn_stop,
  input  logic                up_live,
  input  logic [AW-1:0]       up_start,
  input  logic [AW-1:0]       up_stop,
  output logic                cur_live,
  output logic [AW-1:0]       cur_start,
  output logic [AW-1:0]       cur_stop
);
  import airx_pkg::*;

  localparam bit            HAS_DN = (IDX > 0);
  localparam bit            HAS_UP = (IDX < NCELL - 1);
  localparam bit            MY_PAR = ((IDX % 2) == 1);
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic          live_r, live_nxt;
  logic [AW-1:0] start_r, start_nxt;
  logic [AW-1:0] stop_r, stop_nxt;

  // Order: live entries by start then stop, dead entries last.
  function automatic logic ahead(logic al, logic [AW-1:0] as, logic [AW-1:0] ae,
                                 logic bl, logic [AW-1:0] bs, logic [AW-1:0] be);
    return al && (!bl || (as < bs) || ((as == bs) && (ae < be)));
  endfunction

  always_comb begin
    live_nxt  = live_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    unique case (ctl.op)
      C_HOLD: begin
      end
      C_LOAD: begin
        live_nxt = (MY_IDX < sel);
      end
      C_WRITE: begin
        if (MY_IDX == sel) begin
          start_nxt = wr_start;
          stop_nxt  = wr_stop;
        end
      end
      C_SHIFT: begin
        live_nxt  = up_live;
        start_nxt = up_start;
        stop_nxt  = up_stop;
      end
      C_SORT: begin
        if (MY_PAR == ctl.phase) begin
          // lower cell of the pair keeps the smaller word
          if (HAS_UP && ahead(up_live, up_start, up_stop, live_r, start_r, stop_r)) begin
            live_nxt  = up_live;
            start_nxt = up_start;
            stop_nxt  = up_stop;
          end
        end else begin
          if (HAS_DN && ahead(live_r, start_r, stop_r, dn_live, dn_start, dn_stop)) begin
            live_nxt  = dn_live;
            start_nxt = dn_start;
            stop_nxt  = dn_stop;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    live_r  <= live_nxt;
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
  end

  assign cur_live  = live_r;
  assign cur_start = start_r;
  assign cur_stop  = stop_r;

endmodule

// ----- rtl/core/airx_head.sv -----
module airx_head #(
  parameter int AW = 64,
  parameter int CW = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  airx_pkg::head_ctl_t ctl,
  input  logic [AW-1:0]       q_base,
  input  logic [AW-1:0]       q_stop,
  input  logic                hd_live,
  input  logic [AW-1:0]       hd_start,
  input  logic [AW-1:0]       hd_stop,
  output logic                fd_live,
  output logic [AW-1:0]       fd_start,
  output logic [AW-1:0]       fd_stop,
  output logic [CW-1:0]       emits,
  output logic                hit_nxt
);
  import airx_pkg::*;

  logic          acc_v_r, acc_v_nxt;
  logic [AW-1:0] acc_s_r, acc_s_nxt;
  logic [AW-1:0] acc_e_r, acc_e_nxt;
  logic [CW-1:0] emits_r, emits_nxt;
  logic          ans_r, ans_nxt;

  always_comb begin
    acc_v_nxt = acc_v_r;
    acc_s_nxt = acc_s_r;
    acc_e_nxt = acc_e_r;
    emits_nxt = emits_r;
    ans_nxt   = ans_r;
    fd_live   = hd_live;
    fd_start  = hd_start;
    fd_stop   = hd_stop;
    if (ctl.clr) begin
      acc_v_nxt = 1'b0;
      emits_nxt = '0;
      ans_nxt   = 1'b0;
    end
    unique case (ctl.mode)
      H_IDLE: begin
      end
      H_SCAN: begin
        // last live word starting at or below the base decides
        if (hd_live && (hd_start <= q_base)) begin
          ans_nxt = (hd_stop >= q_stop);
        end
      end
      H_MERGE: begin
        if (hd_live && acc_v_r && (hd_start <= acc_e_r)) begin
          // absorb into the open run, push a dead word
          fd_live = 1'b0;
          if (hd_stop > acc_e_r) begin
            acc_e_nxt = hd_stop;
          end
        end else begin
          // close the open run and start a new one
          fd_live  = acc_v_r;
          fd_start = acc_s_r;
          fd_stop  = acc_e_r;
          if (acc_v_r) begin
            emits_nxt = emits_r + CW'(1);
          end
          acc_v_nxt = hd_live;
          acc_s_nxt = hd_start;
          acc_e_nxt = hd_stop;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_v_r <= 1'b0;
      emits_r <= '0;
      ans_r   <= 1'b0;
    end else begin
      acc_v_r <= acc_v_nxt;
      emits_r <= emits_nxt;
      ans_r   <= ans_nxt;
    end
    acc_s_r <= acc_s_nxt;
    acc_e_r <= acc_e_nxt;
  end

  assign emits   = emits_r;
  assign hit_nxt = ans_nxt;

endmodule

// ----- rtl/core/address_range_index.sv -----
// Address range index: a table of half-open ranges [base, base+size).
//
// Input channel: drive in_word and raise start; the word is taken at a
// rising edge where start is high and busy is low. req_type picks clear,
// add, finalize (sort and merge) or containment query.
// Result channel: out_word is shown for one cycle with out_valid high and
// must be taken then; the receiver cannot stall the block.
//
// Storage is a row of MAX_RANGES+1 cells; at least one always holds a dead word.
// Cells swap with neighbors (odd-even transposition) or shift toward the
// head, where one unit merges runs or answers a query.
// Clear, add, repeated finalize and a trivially false query leave busy low,
// so such words can follow back to back. A query takes one full rotation
// of the row. A finalize runs a sort, a merging rotation and a compacting
// sort, each one step per cell.
// Reset clears the entry count and the finalized flag; the table contents
// are undefined until written.
module address_range_index #(
  parameter int MAX_RANGES = 64,
  parameter int ADDR_BITS  = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  airx_pkg::in_word_t  in_word,
  output logic                out_valid,
  output airx_pkg::out_word_t out_word
);
  import airx_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int NCELL = MAX_RANGES + 1;
  localparam int CW    = $clog2(MAX_RANGES + 1);
  localparam int RW    = $clog2(NCELL);
  localparam logic [RW-1:0] RND_LAST = RW'(NCELL - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_RANGES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SORT  = 4'b0010,
    ST_MERGE = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          merged_r, merged_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic          phase_r, phase_nxt;
  logic          pass_r, pass_nxt;
  logic [AW-1:0] qb_r, qb_nxt;
  logic [AW-1:0] qe_r, qe_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_word_t     out_word_r, out_word_nxt;

  logic          accept;
  logic [AW-1:0] base, size, stop_sat;
  logic [AW:0]   sum;
  logic          bad_rng;

  cell_ctl_t     cell_ctl;
  head_ctl_t     head_ctl;
  logic          cl_live  [NCELL];
  logic [AW-1:0] cl_start [NCELL];
  logic [AW-1:0] cl_stop  [NCELL];
  logic          fd_live;
  logic [AW-1:0] fd_start, fd_stop;
  logic [CW-1:0] emits;
  logic          hit_nxt;

  // Entry count modulo 128 for the result word.
  function automatic logic [6:0] held7(logic [CW-1:0] c);
    logic [CW+6:0] w;
    w = {7'b0, c};
    return w[6:0];
  endfunction

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Stop address saturates at the top of the address space.
  assign base     = in_word.base_address[AW-1:0];
  assign size     = in_word.range_size[AW-1:0];
  assign sum      = {1'b0, base} + {1'b0, size};
  assign stop_sat = sum[AW] ? {AW{1'b1}} : sum[AW-1:0];
  assign bad_rng  = (size == '0) || (stop_sat <= base);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    merged_nxt    = merged_r;
    rnd_nxt       = rnd_r;
    phase_nxt     = phase_r;
    pass_nxt      = pass_r;
    qb_nxt        = qb_r;
    qe_nxt        = qe_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    cell_ctl.op    = C_HOLD;
    cell_ctl.phase = phase_r;
    head_ctl.mode  = H_IDLE;
    head_ctl.clr   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          unique case (in_word.req_type)
            REQ_CLEAR: begin
              cnt_nxt      = '0;
              merged_nxt   = 1'b0;
              out_word_nxt = '{answer: 1'b1, entries_held: 7'd0};
            end
            REQ_ADD: begin
              if (bad_rng || (cnt_r == CNT_FULL)) begin
                out_word_nxt = '{answer: 1'b0, entries_held: held7(cnt_r)};
              end else begin
                // write the word into the cell at the current count
                cell_ctl.op  = C_WRITE;
                cnt_nxt      = cnt_r + CW'(1);
                merged_nxt   = 1'b0;
                out_word_nxt = '{answer: 1'b1, entries_held: held7(cnt_r + CW'(1))};
              end
            end
            REQ_FINAL: begin
              if (merged_r) begin
                out_word_nxt = '{answer: 1'b1, entries_held: held7(cnt_r)};
              end else begin
                // mark cells below the count live, start the first sort
                out_valid_nxt = 1'b0;
                cell_ctl.op   = C_LOAD;
                head_ctl.clr  = 1'b1;
                state_nxt     = ST_SORT;
                rnd_nxt       = '0;
                phase_nxt     = 1'b0;
                pass_nxt      = 1'b0;
              end
            end
            REQ_QUERY: begin
              if ((cnt_r == '0) || bad_rng || !merged_r) begin
                out_word_nxt = '{answer: 1'b0, entries_held: held7(cnt_r)};
              end else begin
                out_valid_nxt = 1'b0;
                head_ctl.clr  = 1'b1;
                qb_nxt        = base;
                qe_nxt        = stop_sat;
                state_nxt     = ST_SCAN;
                rnd_nxt       = '0;
              end
            end
          endcase
        end
      end
      ST_SORT: begin
        cell_ctl.op = C_SORT;
        rnd_nxt     = rnd_r + RW'(1);
        phase_nxt   = !phase_r;
        if (rnd_r == RND_LAST) begin
          rnd_nxt   = '0;
          phase_nxt = 1'b0;
          if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_MERGE;
          end else begin
            // compacted: live words now sit at the bottom of the row
            state_nxt     = ST_IDLE;
            cnt_nxt       = emits;
            merged_nxt    = 1'b1;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{answer: 1'b1, entries_held: held7(emits)};
          end
        end
      end
      ST_MERGE: begin
        cell_ctl.op   = C_SHIFT;
        head_ctl.mode = H_MERGE;
        rnd_nxt       = rnd_r + RW'(1);
        if (rnd_r == RND_LAST) begin
          rnd_nxt   = '0;
          state_nxt = ST_SORT;
        end
      end
      ST_SCAN: begin
        cell_ctl.op   = C_SHIFT;
        head_ctl.mode = H_SCAN;
        rnd_nxt       = rnd_r + RW'(1);
        if (rnd_r == RND_LAST) begin
          rnd_nxt       = '0;
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{answer: hit_nxt, entries_held: held7(cnt_r)};
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      merged_r    <= 1'b0;
      rnd_r       <= '0;
      phase_r     <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      merged_r    <= merged_nxt;
      rnd_r       <= rnd_nxt;
      phase_r     <= phase_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qb_r       <= qb_nxt;
    qe_r       <= qe_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Row of cells: cell 0 is the head, the last cell takes the feed word.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    localparam int DN = (i > 0) ? i - 1 : i;
    logic          up_live;
    logic [AW-1:0] up_start, up_stop;

    if (i < NCELL - 1) begin : g_mid
      assign up_live  = cl_live[i+1];
      assign up_start = cl_start[i+1];
      assign up_stop  = cl_stop[i+1];
    end else begin : g_tail
      assign up_live  = fd_live;
      assign up_start = fd_start;
      assign up_stop  = fd_stop;
    end

    airx_cell #(
      .AW    (AW),
      .CW    (CW),
      .IDX   (i),
      .NCELL (NCELL)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .sel       (cnt_r),
      .wr_start  (base),
      .wr_stop   (stop_sat),
      .dn_live   (cl_live[DN]),
      .dn_start  (cl_start[DN]),
      .dn_stop   (cl_stop[DN]),
      .up_live   (up_live),
      .up_start  (up_start),
      .up_stop   (up_stop),
      .cur_live  (cl_live[i]),
      .cur_start (cl_start[i]),
      .cur_stop  (cl_stop[i])
    );
  end

  airx_head #(
    .AW (AW),
    .CW (CW)
  ) u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (head_ctl),
    .q_base   (qb_r),
    .q_stop   (qe_r),
    .hd_live  (cl_live[0]),
    .hd_start (cl_start[0]),
    .hd_stop  (cl_stop[0]),
    .fd_live  (fd_live),
    .fd_start (fd_start),
    .fd_stop  (fd_stop),
    .emits    (emits),
    .hit_nxt  (hit_nxt)
  );

endmodule

// ----- verif/tb_address_range_index.sv -----
`timescale 1ns / 1ps

module tb_address_range_index;
  import airx_pkg::*;

  localparam int          NRANGE       = 64;
  localparam logic [63:0] ADDR_TOP     = '1;
  localparam int          RANDOM_ITEMS = 400;
  // Slowest word: finalize; the longest sender gap comes on top of it.
  // Allow a wide margin on top of both.
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 3 * (NRANGE + 1) + 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_valid;
  out_word_t out_word;

  address_range_index #(
    .MAX_RANGES(NRANGE),
    .ADDR_BITS (64)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the range table: entries below tbl_n are valid, tbl_merged
  // says whether they are sorted and coalesced.
  // ---------------------------------------------------------------------
  logic [63:0] tbl_lo [NRANGE];
  logic [63:0] tbl_hi [NRANGE];
  int          tbl_n = 0;
  bit          tbl_merged = 1'b0;

  in_word_t  req_backlog [$];   // words not yet offered to the block
  out_word_t answers_due [$];   // predicted results, oldest first
  int        mismatches = 0;

  // Exclusive end of a range, clamped at the top address.
  function automatic logic [63:0] stop_for(logic [63:0] b, logic [63:0] s);
    if (s > ADDR_TOP - b) return ADDR_TOP;
    return b + s;
  endfunction

  // Insertion sort by (lo, hi), then fold overlapping or touching entries.
  function automatic void coalesce_table();
    logic [63:0] t_lo, t_hi;
    int          w;
    for (int i = 1; i < tbl_n; i++) begin
      for (int j = i; j > 0; j--) begin
        if (!(tbl_lo[j] < tbl_lo[j-1] ||
              (tbl_lo[j] == tbl_lo[j-1] && tbl_hi[j] < tbl_hi[j-1])))
          break;
        t_lo = tbl_lo[j];
        t_hi = tbl_hi[j];
        tbl_lo[j] = tbl_lo[j-1];
        tbl_hi[j] = tbl_hi[j-1];
        tbl_lo[j-1] = t_lo;
        tbl_hi[j-1] = t_hi;
      end
    end
    w = 0;
    for (int i = 0; i < tbl_n; i++) begin
      t_lo = tbl_lo[i];
      t_hi = tbl_hi[i];
      if (w > 0 && t_lo <= tbl_hi[w-1]) begin
        if (t_hi > tbl_hi[w-1]) tbl_hi[w-1] = t_hi;
      end else begin
        tbl_lo[w] = t_lo;
        tbl_hi[w] = t_hi;
        w++;
      end
    end
    tbl_n = w;
    tbl_merged = 1'b1;
  endfunction

  // Containment: the last merged entry starting at or below b must reach
  // the query's end.
  function automatic logic range_covered(logic [63:0] b, logic [63:0] s);
    logic [63:0] e;
    int          hit;
    if (tbl_n == 0 || s == 0 || !tbl_merged) return 1'b0;
    e = stop_for(b, s);
    if (e <= b) return 1'b0;
    hit = -1;
    for (int i = 0; i < tbl_n; i++) begin
      if (tbl_lo[i] <= b) hit = i;
      else break;
    end
    if (hit < 0) return 1'b0;
    return tbl_hi[hit] >= e;
  endfunction

  // Apply one request to the shadow table and return the result word.
  function automatic out_word_t index_step(in_word_t w);
    out_word_t   r;
    logic [63:0] b, s, e;
    b = w.base_address;
    s = w.range_size;
    e = stop_for(b, s);
    r.answer = 1'b1;
    case (req_t'(w.req_type))
      REQ_CLEAR: begin
        tbl_n = 0;
        tbl_merged = 1'b0;
      end
      REQ_ADD: begin
        if (s == 0 || e <= b || tbl_n >= NRANGE) begin
          r.answer = 1'b0;
        end else begin
          tbl_lo[tbl_n] = b;
          tbl_hi[tbl_n] = e;
          tbl_n++;
          tbl_merged = 1'b0;
        end
      end
      REQ_FINAL: begin
        if (!tbl_merged) coalesce_table();
      end
      default: begin
        r.answer = range_covered(b, s);
      end
    endcase
    r.entries_held = 7'(tbl_n);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------
  function automatic logic [63:0] rand_wide();
    return {$urandom(), $urandom()};
  endfunction

  // Address styles: 0 dense low window (lots of overlap), 1 full 64-bit,
  // 2 right under the top address (saturation).
  function automatic logic [63:0] pick_base(int unsigned style);
    case (style)
      0:       return 64'($urandom_range(0, 4095));
      1:       return rand_wide();
      default: return ADDR_TOP - 64'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [63:0] pick_size(int unsigned style);
    case (style)
      0:       return 64'($urandom_range(1, 300));
      1:       return rand_wide() >> $urandom_range(0, 63);
      default: return 64'($urandom_range(1, 8000));
    endcase
  endfunction

  task automatic queue_req(req_t kind, logic [63:0] base, logic [63:0] size);
    in_word_t w;
    w.req_type     = kind;
    w.base_address = base;
    w.range_size   = size;
    req_backlog.push_back(w);
  endtask

  // One well-formed session: (clear), adds, finalize, queries aimed at
  // the ranges just added. Now and then a full table or a stray word.
  task automatic queue_session();
    int unsigned style, n_add, n_query, idx, pick;
    logic [63:0] b, s, e, room;
    logic [63:0] span_lo [$];
    logic [63:0] span_hi [$];
    pick  = $urandom_range(0, 9);
    style = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
    b = '0;
    s = '0;
    if ($urandom_range(0, 9) < 7) queue_req(REQ_CLEAR, rand_wide(), rand_wide());
    n_add = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 70) : $urandom_range(1, 12);
    for (int i = 0; i < n_add; i++) begin
      b = pick_base(style);
      s = ($urandom_range(0, 19) == 0) ? 64'd0 : pick_size(style);
      queue_req(REQ_ADD, b, s);
      e = stop_for(b, s);
      if (s != 0 && e > b) begin
        span_lo.push_back(b);
        span_hi.push_back(e);
      end
    end
    // query against an unfinalized table
    if ($urandom_range(0, 9) == 0) queue_req(REQ_QUERY, b, s);
    queue_req(REQ_FINAL, rand_wide(), rand_wide());
    if ($urandom_range(0, 4) == 0) queue_req(REQ_FINAL, rand_wide(), rand_wide());
    n_query = $urandom_range(2, 10);
    for (int i = 0; i < n_query; i++) begin
      if (span_lo.size() == 0 || $urandom_range(0, 9) == 0) begin
        queue_req(REQ_QUERY, pick_base(style), pick_size(style));
      end else begin
        idx  = $urandom_range(0, span_lo.size() - 1);
        room = span_hi[idx] - span_lo[idx];
        b    = span_lo[idx] + rand_wide() % room;
        room = span_hi[idx] - b;
        // half land inside the range, half run to or past its end
        if ($urandom_range(0, 1) == 1) s = 64'd1 + rand_wide() % room;
        else s = room + 64'($urandom_range(0, 64));
        queue_req(REQ_QUERY, b, s);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer words from the backlog in bursts with random gaps.
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    logic        took;
    int unsigned roll;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      // predict at the accept edge; the result shows up in the next cycle at the earliest
      if (took) answers_due.push_back(index_step(in_word));
      if (start && !took) begin
        // hold the word until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        in_word <= req_backlog.pop_front();
        start   <= 1'b1;
        if (burst_left <= 1) begin
          // end of burst: pick the next burst length and the gap before it
          burst_left = $urandom_range(1, 16);
          roll = $urandom_range(0, 99);
          gap_left = (roll < 40) ? 0 :
                     (roll < 90) ? $urandom_range(1, 8) : $urandom_range(9, 220);
        end else begin
          burst_left--;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobed result word is matched against the oldest
  // prediction; the receiver cannot stall, so take each one as it comes.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result word: answer=%0b entries_held=%0d",
               out_word.answer, out_word.entries_held);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (out_word.answer !== want.answer) begin
          $error("answer: expected %0b, got %0b", want.answer, out_word.answer);
          mismatches++;
        end
        if (out_word.entries_held !== want.entries_held) begin
          $error("entries_held: expected %0d, got %0d",
                 want.entries_held, out_word.entries_held);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: count cycles where no word moves in either direction.
  // ---------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed words, random sessions, reset, drain.
  // ---------------------------------------------------------------------
  initial begin
    int n_directed;

    // empty table: query before and after finalize
    queue_req(REQ_QUERY, 64'd0, 64'd1);
    queue_req(REQ_FINAL, 64'd0, 64'd0);
    queue_req(REQ_QUERY, 64'd0, 64'd1);
    // rejected adds: zero size, end stuck at the top address
    queue_req(REQ_ADD, 64'd100, 64'd0);
    queue_req(REQ_ADD, ADDR_TOP, 64'd1);
    // end saturates but stays above base
    queue_req(REQ_ADD, ADDR_TOP - 64'd4, 64'd10);
    // overlapping, touching and nested ranges
    queue_req(REQ_ADD, 64'd100, 64'd50);
    queue_req(REQ_ADD, 64'd150, 64'd20);
    queue_req(REQ_ADD, 64'd120, 64'd10);
    queue_req(REQ_ADD, 64'd400, 64'd16);
    queue_req(REQ_QUERY, 64'd100, 64'd10);     // not finalized yet
    queue_req(REQ_FINAL, 64'd0, 64'd0);
    queue_req(REQ_FINAL, ADDR_TOP, ADDR_TOP);  // already finalized
    queue_req(REQ_QUERY, 64'd99, 64'd1);       // nothing at or below base
    queue_req(REQ_QUERY, 64'd100, 64'd70);     // spans the merged run
    queue_req(REQ_QUERY, 64'd160, 64'd11);     // runs one past its end
    queue_req(REQ_QUERY, 64'd400, 64'd0);      // zero size
    queue_req(REQ_QUERY, ADDR_TOP, 64'd1);     // degenerate query
    queue_req(REQ_QUERY, ADDR_TOP - 64'd2, 64'd1);
    queue_req(REQ_QUERY, ADDR_TOP - 64'd2, ADDR_TOP);
    queue_req(REQ_CLEAR, ADDR_TOP, ADDR_TOP);
    // whole address space as one entry
    queue_req(REQ_ADD, 64'd0, ADDR_TOP);
    queue_req(REQ_FINAL, 64'd0, 64'd0);
    queue_req(REQ_QUERY, 64'd0, ADDR_TOP);
    queue_req(REQ_CLEAR, 64'd0, 64'd0);
    n_directed = req_backlog.size();

    while (req_backlog.size() < n_directed + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        queue_session();
      end else begin
        // noise: arbitrary words of any kind
        repeat ($urandom_range(1, 4))
          queue_req(req_t'($urandom_range(0, 3)), rand_wide(), rand_wide());
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain: every word sent and every result seen, then watch for strays
    while (req_backlog.size() != 0 || start || answers_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
